### hw/rtl/rdgp_pkg.sv
// Shared types, constants and decode helper for the register dependency group profiler.
// No dependencies; imported by every module of the block.
package rdgp_pkg;

	localparam int MAX_SOURCES    = 3;
	localparam int REGS_PER_CLASS = 32;
	localparam int SLOTS          = 3;
	localparam int MAP_W          = 2 * REGS_PER_CLASS;
	localparam int POS_W          = $clog2(MAP_W);
	localparam int CNT_W          = 48;
	localparam int CFG_W          = 16;
	localparam int CLS_W          = 2;
	localparam int IDX_W          = 5;
	localparam int CNTF_W         = 2;
	localparam int KIND_W         = 2;
	localparam int QDEPTH         = 2;
	localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W         = $clog2(QDEPTH + 1);

	localparam int IN_W  = 32;
	localparam int OUT_W = 3 * CNT_W;

	// register classes
	localparam logic [CLS_W-1:0] CLS_INT = 2'd0;
	localparam logic [CLS_W-1:0] CLS_FP  = 2'd1;

	// dependency kinds
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INTRA = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INTER = 2'd2;

	// configuration register indexes
	localparam logic REG_GROUP_SIZE    = 1'b0;
	localparam logic REG_COMMIT_PERIOD = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] pos;
	} reg_ref_t;

	typedef struct packed {
		reg_ref_t [SLOTS-1:0] src;
		reg_ref_t             dest;
	} instr_t;

	typedef struct packed {
		logic [CFG_W-1:0] group_size;
		logic [CFG_W-1:0] commit_period;
	} cfg_t;

	// class/index to map position; valid clear when the register is ignored
	function automatic reg_ref_t reg_decode(input logic [CLS_W-1:0] cls,
	                                        input logic [IDX_W-1:0] idx);
		reg_ref_t r;
		r.valid = 1'b0;
		r.pos   = '0;
		if ({1'b0, idx} < (IDX_W+1)'(REGS_PER_CLASS)) begin
			if (cls == CLS_INT) begin
				r.valid = 1'b1;
				r.pos   = POS_W'(idx);
			end else if (cls == CLS_FP) begin
				r.valid = 1'b1;
				r.pos   = POS_W'(idx) + POS_W'(REGS_PER_CLASS);
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/rdgp_front.sv
// Front end: unpacks an instruction and reduces each register slot to a map position.
// Depends on rdgp_pkg.
module rdgp_front
	import rdgp_pkg::*;
(
	input  logic [IN_W-1:0] tdata,
	output instr_t          instr
);

	logic [CNTF_W-1:0] src_count;
	logic [CLS_W-1:0]  src_class [SLOTS];
	logic [IDX_W-1:0]  src_index [SLOTS];
	logic [CNTF_W:0]   limit;

	assign src_count = tdata[1:0];
	assign limit = (MAX_SOURCES < SLOTS) ? (CNTF_W+1)'(MAX_SOURCES) : (CNTF_W+1)'(SLOTS);

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			src_class[k] = tdata[2 + 7*k +: CLS_W];
			src_index[k] = tdata[4 + 7*k +: IDX_W];
		end
	end

	always_comb begin
		reg_ref_t r;
		for (int k = 0; k < SLOTS; k++) begin
			r = reg_decode(src_class[k], src_index[k]);
			// slot beyond count or limit, or integer zero: no source
			if ((CNTF_W+1)'(k) >= {1'b0, src_count} || (CNTF_W+1)'(k) >= limit)
				r.valid = 1'b0;
			if (src_class[k] == CLS_INT && src_index[k] == '0)
				r.valid = 1'b0;
			instr.src[k] = r;
		end
		instr.dest = reg_decode(tdata[25:24], tdata[30:26]);
		if (!tdata[23])
			instr.dest.valid = 1'b0;
	end

endmodule

### hw/rtl/rdgp_queue.sv
// Short queue between front and back end, holding decoded instructions.
// Depends on rdgp_pkg.
module rdgp_queue
	import rdgp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  instr_t wr_data,
	output instr_t rd_data,
	input  logic   push,
	input  logic   pop,
	output logic   full,
	output logic   avail
);

	instr_t              mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push, do_pop;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign avail = (count_q != '0);

	assign do_push = push && !full;
	assign do_pop  = pop && avail;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### hw/rtl/rdgp_back.sv
// Back end: register maps, group/period positions, classification and counters.
// Depends on rdgp_pkg.
module rdgp_back
	import rdgp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  instr_t             instr,
	input  logic               avail,
	output logic               take,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,
	output logic [KIND_W-1:0]  m_tuser
);

	logic [MAP_W-1:0]  pv_q, prod_q, seen_q;
	logic [CFG_W-1:0]  gpos_q, ppos_q;
	logic [CNT_W-1:0]  dep_q, intra_q, inter_q;
	logic [KIND_W-1:0] kind_q;
	logic              valid_q;

	logic [MAP_W-1:0]  pv_e, prod_e, seen_e, seen_add, dbit;
	logic [MAP_W-1:0]  sbit [SLOTS];
	logic [SLOTS-1:0]  hit, fresh;
	logic              first, dependent, intra;
	logic [CFG_W-1:0]  gsize, period;
	logic              g_end, p_end;

	assign take     = avail && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = {inter_q, intra_q, dep_q};
	assign m_tuser  = kind_q;

	// group start clears the group maps; period start also commits everything
	assign first  = (gpos_q == '0);
	assign pv_e   = (first && ppos_q == '0) ? '0 : pv_q;
	assign prod_e = first ? '0 : prod_q;
	assign seen_e = first ? '0 : seen_q;

	always_comb begin
		seen_add = '0;
		for (int k = 0; k < SLOTS; k++) begin
			sbit[k]  = instr.src[k].valid ? (MAP_W'(1) << instr.src[k].pos) : '0;
			hit[k]   = |(pv_e & sbit[k]);
			fresh[k] = hit[k] && !(|(seen_e & sbit[k])) && !(|(prod_e & sbit[k]));
			if (fresh[k])
				seen_add = seen_add | sbit[k];
		end
	end

	assign dependent = |hit;
	assign intra     = ~|fresh;
	assign dbit      = instr.dest.valid ? (MAP_W'(1) << instr.dest.pos) : '0;

	assign gsize  = (cfg.group_size == '0) ? CFG_W'(1) : cfg.group_size;
	assign period = (cfg.commit_period == '0) ? CFG_W'(1) : cfg.commit_period;
	assign g_end  = ({1'b0, gpos_q} + 1'b1) >= {1'b0, gsize};
	assign p_end  = ({1'b0, ppos_q} + 1'b1) >= {1'b0, period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			prod_q  <= '0;
			seen_q  <= '0;
			gpos_q  <= '0;
			ppos_q  <= '0;
			dep_q   <= '0;
			intra_q <= '0;
			inter_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				pv_q   <= pv_e | dbit;
				prod_q <= prod_e | dbit;
				seen_q <= seen_e | seen_add;
				if (dependent) begin
					dep_q <= dep_q + 1'b1;
					if (intra)
						intra_q <= intra_q + 1'b1;
					else
						inter_q <= inter_q + 1'b1;
				end
				if (g_end) begin
					gpos_q <= '0;
					ppos_q <= p_end ? '0 : ppos_q + 1'b1;
				end else begin
					gpos_q <= gpos_q + 1'b1;
				end
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			kind_q <= !dependent ? KIND_NONE : (intra ? KIND_INTRA : KIND_INTER);
	end

endmodule

### hw/rtl/register_dependency_group_profiler.sv
// Top level of the register dependency group profiler.
// Depends on rdgp_pkg, rdgp_front, rdgp_queue and rdgp_back.
//
// One committed instruction per transaction comes in on the s_ group; one
// result per instruction goes out on the m_ group, in order. The block
// sustains one instruction per clock while m_tready stays high: the back end
// updates the 64-bit register maps and the three 48-bit counters on the edge
// that takes each instruction. An accepted instruction is written into the
// queue and taken by the back end once the result register is free or being
// read; its result is then registered and valid on m_. s_tready drops only
// when the two-entry queue is full, which takes a stall on m_tready while a
// result is waiting; it comes back in the cycle after m_tready returns. Write
// group_size and commit_period only while no results are pending; zero in
// either is treated as one. No clearing pass is needed after reset.
module register_dependency_group_profiler
	import rdgp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// instruction stream
	input  logic               s_tvalid,
	output logic               s_tready,
	// [1:0] src_count, [3:2] src0_class, [8:4] src0_index, [10:9] src1_class,
	// [15:11] src1_index, [17:16] src2_class, [22:18] src2_index,
	// [23] dest_present, [25:24] dest_class, [30:26] dest_index, [31] zero
	input  logic [IN_W-1:0]    s_tdata,
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	// [47:0] dependent_total, [95:48] intra_total, [143:96] inter_total
	output logic [OUT_W-1:0]   m_tdata,
	// [1:0] dep_kind
	output logic [KIND_W-1:0]  m_tuser
);

	cfg_t   cfg_q;
	instr_t front_instr, back_instr;
	logic   q_full, q_avail;
	logic   take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_size    <= CFG_W'(8);
			cfg_q.commit_period <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GROUP_SIZE:    cfg_q.group_size    <= cfg_data;
				REG_COMMIT_PERIOD: cfg_q.commit_period <= cfg_data;
				default:           ;
			endcase
		end
	end

	// front end: decode slots into map positions
	rdgp_front u_front (
		.tdata (s_tdata),
		.instr (front_instr)
	);

	assign s_tready = !q_full;

	// decouples intake from the result handshake
	rdgp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (front_instr),
		.rd_data (back_instr),
		.push    (s_tvalid),
		.pop     (take),
		.full    (q_full),
		.avail   (q_avail)
	);

	// back end: map state, classification, statistics, result register
	rdgp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.instr    (back_instr),
		.avail    (q_avail),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### bench/register_dependency_group_profiler_tb.sv
// Self-checking bench for register_dependency_group_profiler: directed table, then random phases.
// Depends on rdgp_pkg and the RTL top; a built-in predictor checks every result transaction.
module register_dependency_group_profiler_tb;
	import rdgp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// class codes the block ignores
	localparam logic [CLS_W-1:0] CLS_OTHER = 2'd2;
	localparam logic [CLS_W-1:0] CLS_RSVD  = 2'd3;

	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 170;

	// one result transaction: m_tuser plus the three totals in m_tdata
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CNT_W-1:0]  dependent;
		logic [CNT_W-1:0]  intra;
		logic [CNT_W-1:0]  inter;
	} profile_t;

	// directed row: optional reconfiguration first, then one instruction
	typedef struct packed {
		logic              reconf;
		logic [CFG_W-1:0]  gsize;
		logic [CFG_W-1:0]  period;
		logic [IN_W-1:0]   word;
		logic              typed;
		profile_t          res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;
	logic [KIND_W-1:0]  m_tuser;

	// predictor state
	logic [CFG_W-1:0]  gsize_reg;
	logic [CFG_W-1:0]  period_reg;
	logic [MAP_W-1:0]  pend_map;     // produced, not yet committed
	logic [MAP_W-1:0]  written_map;  // produced in the current group
	logic [MAP_W-1:0]  seen_map;     // inter-group sources already counted this group
	logic [15:0]       grp_pos;
	logic [15:0]       per_pos;
	logic [CNT_W-1:0]  dep_cnt;
	logic [CNT_W-1:0]  intra_cnt;
	logic [CNT_W-1:0]  inter_cnt;

	profile_t  profile_q[$];   // predicted results, oldest first
	dir_row_t  dir_tab[$];
	int        mismatches;
	bit        calm;           // no gaps and no stalls while set

	register_dependency_group_profiler uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [IN_W-1:0] mk_word(
		input logic [1:0] cnt,
		input logic [1:0] c0, input logic [4:0] i0,
		input logic [1:0] c1, input logic [4:0] i1,
		input logic [1:0] c2, input logic [4:0] i2,
		input logic dp, input logic [1:0] dc, input logic [4:0] di);
		return {1'b0, di, dc, dp, i2, c2, i1, c1, i0, c0, cnt};
	endfunction

	function automatic profile_t mk_res(input logic [KIND_W-1:0] k, input int d,
	                                    input int a, input int x);
		profile_t p;
		p.kind      = k;
		p.dependent = CNT_W'(d);
		p.intra     = CNT_W'(a);
		p.inter     = CNT_W'(x);
		return p;
	endfunction

	// append one row to the directed table
	task automatic add_row(input dir_row_t r);
		dir_tab = {dir_tab, r};
	endtask

	// map bit of a register; zero when the class is ignored
	function automatic logic [MAP_W-1:0] reg_mask(input logic [1:0] cls, input logic [4:0] idx);
		if (cls == CLS_INT)
			return 64'd1 << int'(idx);
		if (cls == CLS_FP)
			return 64'd1 << (int'(idx) + REGS_PER_CLASS);
		return '0;
	endfunction

	// advance the predictor by one instruction and return the result it causes
	function automatic profile_t profile_next(input logic [IN_W-1:0] w);
		profile_t          p;
		int                nsrc;
		int                gs;
		int                cp;
		logic [1:0]        c;
		logic [4:0]        x;
		logic [MAP_W-1:0]  m;
		bit                dep;
		bit                local_only;
		gs = (gsize_reg == 0) ? 1 : int'(gsize_reg);
		cp = (period_reg == 0) ? 1 : int'(period_reg);
		if (grp_pos == 0) begin
			seen_map    = '0;
			written_map = '0;
			if (per_pos == 0)
				pend_map = '0;
		end
		nsrc = int'(w[1:0]);
		if (nsrc > MAX_SOURCES)
			nsrc = MAX_SOURCES;
		dep        = 1'b0;
		local_only = 1'b1;
		for (int k = 0; k < nsrc; k++) begin
			c = w[2 + 7*k +: 2];
			x = w[4 + 7*k +: 5];
			// x0 never carries a dependency
			if (!(c == CLS_INT && x == 0)) begin
				m = reg_mask(c, x);
				if ((m & pend_map) != 0) begin
					dep = 1'b1;
					if ((m & seen_map) == 0 && (m & written_map) == 0) begin
						local_only = 1'b0;
						seen_map   = seen_map | m;
					end
				end
			end
		end
		// destination lands after the sources are looked at
		if (w[23]) begin
			m           = reg_mask(w[25:24], w[30:26]);
			pend_map    = pend_map | m;
			written_map = written_map | m;
		end
		p.kind = KIND_NONE;
		if (dep) begin
			dep_cnt = dep_cnt + 1'b1;
			if (local_only) begin
				intra_cnt = intra_cnt + 1'b1;
				p.kind    = KIND_INTRA;
			end else begin
				inter_cnt = inter_cnt + 1'b1;
				p.kind    = KIND_INTER;
			end
		end
		// >= so that a size lowered below the position closes the group now
		if (int'(grp_pos) + 1 >= gs) begin
			grp_pos = '0;
			if (int'(per_pos) + 1 >= cp)
				per_pos = '0;
			else
				per_pos = per_pos + 1'b1;
		end else begin
			grp_pos = grp_pos + 1'b1;
		end
		p.dependent = dep_cnt;
		p.intra     = intra_cnt;
		p.inter     = inter_cnt;
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// register pick biased to a small pool so dependencies are frequent
	function automatic logic [6:0] pick_reg();
		int          r;
		logic [1:0]  c;
		logic [4:0]  x;
		r = $urandom_range(0, 99);
		if (r < 46)
			c = CLS_INT;
		else if (r < 92)
			c = CLS_FP;
		else if (r < 96)
			c = CLS_OTHER;
		else
			c = CLS_RSVD;
		if ($urandom_range(0, 3) != 0)
			x = 5'($urandom_range(0, 7));
		else
			x = 5'($urandom_range(0, 31));
		return {x, c};
	endfunction

	function automatic logic [IN_W-1:0] rand_instr();
		logic [IN_W-1:0] w;
		logic [6:0]      s0;
		logic [6:0]      s1;
		logic [6:0]      s2;
		logic [6:0]      d;
		// a tenth is raw noise so that every bit below bit 31 toggles
		if ($urandom_range(0, 9) == 0) begin
			w     = $urandom();
			w[31] = 1'b0;
			return w;
		end
		s0 = pick_reg();
		s1 = pick_reg();
		s2 = pick_reg();
		d  = pick_reg();
		return mk_word(2'($urandom_range(0, 3)), s0[1:0], s0[6:2], s1[1:0], s1[6:2],
		               s2[1:0], s2[6:2], ($urandom_range(0, 99) < 85), d[1:0], d[6:2]);
	endfunction

	// one instruction transaction; prediction is taken at acceptance
	task automatic drive_instr(input logic [IN_W-1:0] w, input bit typed, input profile_t res);
		int        gap;
		profile_t  p;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		p = profile_next(w);
		profile_q = {profile_q, (typed ? res : p)};
	endtask

	// sender stops until every predicted result has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (profile_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_GROUP_SIZE)
			gsize_reg = val;
		else
			period_reg = val;
	endtask

	task automatic reconfigure(input logic [CFG_W-1:0] gs, input logic [CFG_W-1:0] cp);
		drain();
		write_reg(REG_GROUP_SIZE, gs);
		write_reg(REG_COMMIT_PERIOD, cp);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, mostly short, a few long
	initial begin : sink
		int stall_left;
		int open_left;
		stall_left = 0;
		open_left  = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (open_left > 0) begin
				m_tready <= 1'b1;
				open_left--;
			end else begin
				open_left = $urandom_range(0, 12);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: stall_left = 0;
					5, 6, 7: stall_left = $urandom_range(1, 3);
					8: stall_left = $urandom_range(4, 12);
					default: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 2;
				endcase
				m_tready <= (stall_left == 0);
			end
		end
	end

	// result check
	always @(posedge clk) begin : result_check
		profile_t got;
		profile_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind      = m_tuser;
			got.dependent = m_tdata[CNT_W-1:0];
			got.intra     = m_tdata[2*CNT_W-1:CNT_W];
			got.inter     = m_tdata[3*CNT_W-1:2*CNT_W];
			if (profile_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result kind=%0d dep=%0d intra=%0d inter=%0d",
					         $realtime, got.kind, got.dependent, got.intra, got.inter);
			end else begin
				want = profile_q.pop_front();
				if (got.kind !== want.kind || got.dependent !== want.dependent ||
				    got.intra !== want.intra || got.inter !== want.inter) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: result mismatch exp kind=%0d dep=%0d intra=%0d ",
						          "inter=%0d, got kind=%0d dep=%0d intra=%0d inter=%0d"},
						         $realtime, want.kind, want.dependent, want.intra,
						         want.inter, got.kind, got.dependent, got.intra,
						         got.inter);
				end
			end
		end
	end

	initial begin : stimulus
		profile_t    none_res;
		logic [15:0] gs;
		logic [15:0] cp;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_GROUP_SIZE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		calm      = 1'b0;
		mismatches = 0;

		// predictor matches the block's reset state
		gsize_reg   = 16'd8;
		period_reg  = 16'd1;
		pend_map    = '0;
		written_map = '0;
		seen_map    = '0;
		grp_pos     = '0;
		per_pos     = '0;
		dep_cnt     = '0;
		intra_cnt   = '0;
		inter_cnt   = '0;
		none_res    = '0;

		// Directed table. Rows with typed=1 are checked against the literal result;
		// they run at the reset setting (groups of eight, commit every group).
		// nothing produced yet
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd3, CLS_INT, 5'd5, CLS_FP, 5'd31, CLS_INT, 5'd31, 1'b1, CLS_INT, 5'd1),
			1'b1, mk_res(KIND_NONE, 0, 0, 0)});
		// x1 written earlier in this group
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd1, CLS_INT, 5'd1, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_FP, 5'd31),
			1'b1, mk_res(KIND_INTRA, 1, 1, 0)});
		// x0 as source is ignored, as destination it is recorded
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd1, CLS_INT, 5'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_INT, 5'd0),
			1'b1, mk_res(KIND_NONE, 1, 1, 0)});
		// x0 again, plus the two ignored classes
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd3, CLS_INT, 5'd0, CLS_OTHER, 5'd5, CLS_RSVD, 5'd31, 1'b1, CLS_OTHER, 5'd3),
			1'b1, mk_res(KIND_NONE, 1, 1, 0)});
		// zero source slots, destination flag clear
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd0, CLS_FP, 5'd31, CLS_FP, 5'd31, CLS_INT, 5'd1, 1'b0, CLS_FP, 5'd2),
			1'b1, mk_res(KIND_NONE, 1, 1, 0)});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd3, CLS_FP, 5'd31, CLS_FP, 5'd31, CLS_INT, 5'd1, 1'b0, CLS_INT, 5'd0),
			1'b1, mk_res(KIND_INTRA, 2, 2, 0)});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_INT, 5'd7),
			1'b1, mk_res(KIND_NONE, 2, 2, 0)});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_FP, 5'd0),
			1'b1, mk_res(KIND_NONE, 2, 2, 0)});
		// new group: everything committed again, x7 no longer counts
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd1, CLS_INT, 5'd7, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_INT, 5'd9),
			1'b1, mk_res(KIND_NONE, 2, 2, 0)});
		// pairs of instructions, commit every third group: inter-group cases;
		// this write sets the size just above the current position, so this row ends the group
		add_row('{1'b1, 16'd2, 16'd3,
			mk_word(2'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_INT, 5'd3),
			1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd1, CLS_INT, 5'd3, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_FP, 5'd4),
			1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd3, CLS_INT, 5'd3, CLS_INT, 5'd3, CLS_FP, 5'd4, 1'b1, CLS_INT, 5'd3),
			1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd2, CLS_INT, 5'd3, CLS_FP, 5'd4, CLS_INT, 5'd0, 1'b0, CLS_INT, 5'd0),
			1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd3, CLS_INT, 5'd31, CLS_INT, 5'd31, CLS_INT, 5'd31, 1'b1, CLS_INT, 5'd31),
			1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd1, CLS_INT, 5'd31, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b0, CLS_INT, 5'd0),
			1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd2, CLS_INT, 5'd31, CLS_INT, 5'd3, CLS_INT, 5'd0, 1'b0, CLS_INT, 5'd0),
			1'b0, none_res});
		// all fields at their top, then all zero
		add_row('{1'b0, 16'd0, 16'd0, 32'h7FFF_FFFF, 1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0, 32'h0000_0000, 1'b0, none_res});
		// zero in both registers acts as one
		add_row('{1'b1, 16'd0, 16'd0,
			mk_word(2'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_FP, 5'd9),
			1'b0, none_res});
		add_row('{1'b0, 16'd0, 16'd0,
			mk_word(2'd1, CLS_FP, 5'd9, CLS_INT, 5'd0, CLS_INT, 5'd0, 1'b1, CLS_FP, 5'd9),
			1'b0, none_res});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].reconf)
				reconfigure(dir_tab[i].gsize, dir_tab[i].period);
			drive_instr(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);
		end

		// random phases; each writes both registers with the sender held off
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin gs = 16'd1; cp = 16'd1; end
				1: begin gs = 16'd1; cp = 16'd65535; end
				2: begin gs = 16'd65535; cp = 16'd1; end
				3: begin gs = 16'd65535; cp = 16'd3; end
				4: begin gs = 16'd3; cp = 16'd2; end        // far below the position
				5: begin gs = 16'd65535; cp = 16'd65535; end
				6: begin gs = 16'd2; cp = 16'd65535; end
				default: begin
					gs = 16'($urandom_range(1, 12));
					cp = 16'($urandom_range(1, 6));
				end
			endcase
			reconfigure(gs, cp);
			calm = (ph == 2 || ph == 7);
			for (int n = 0; n < PHASE_ITEMS; n++)
				drive_instr(rand_instr(), 1'b0, none_res);
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && profile_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/rdgp_pkg.sv
hw/rtl/rdgp_front.sv
hw/rtl/rdgp_queue.sv
hw/rtl/rdgp_back.sv
hw/rtl/register_dependency_group_profiler.sv
bench/register_dependency_group_profiler_tb.sv
